>>> src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the three-point Steiner length block
// Word layouts for the point triple and the result, and default sizes.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int COORD_BITS_DEF = 32;   // default coordinate width
    localparam int IN_W           = 32;   // width of each coordinate field
    localparam int OUT_W          = 34;   // width of the length field

    typedef struct packed {
        logic signed [IN_W-1:0] point_a_x;
        logic signed [IN_W-1:0] point_a_y;
        logic signed [IN_W-1:0] point_b_x;
        logic signed [IN_W-1:0] point_b_y;
        logic signed [IN_W-1:0] point_c_x;
        logic signed [IN_W-1:0] point_c_y;
    } t_points;

    typedef struct packed {
        logic [OUT_W-1:0] network_length;
        logic             obtuse_case;
    } t_result;

endpackage

>>> src/tps_mul_cell.sv
// ----------------------------------------------------------------------------
// tps_mul_cell: one step of a shift-add multiplier chain
// Fold in one multiplier bit, MSB first, and pass the operands on.
// ----------------------------------------------------------------------------
module tps_mul_cell #(
    parameter int AW = 8,
    parameter int BW = 8,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    input  logic [AW+BW-1:0] i_acc,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [AW-1:0]    o_a,
    output logic [BW-1:0]    o_b,
    output logic [AW+BW-1:0] o_acc,
    output logic [SW-1:0]    o_side
);
    localparam int PW = AW + BW;

    logic             r_valid;
    logic [AW-1:0]    r_a;
    logic [BW-1:0]    r_b;
    logic [PW-1:0]    r_acc;
    logic [SW-1:0]    r_side;
    logic [PW-1:0]    n_acc;

    always_comb begin
        n_acc = {i_acc[PW-2:0], 1'b0} + (i_b[BW-1] ? PW'(i_a) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_a    <= i_a;
        r_b    <= {i_b[BW-2:0], 1'b0};
        r_acc  <= n_acc;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule

>>> src/tps_mul_chain.sv
// ----------------------------------------------------------------------------
// tps_mul_chain: pipelined multiplier built from a row of shift-add cells
// One cell per multiplier bit; a new word may enter every cycle.
// ----------------------------------------------------------------------------
module tps_mul_chain #(
    parameter int AW = 8,
    parameter int BW = 8,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [AW+BW-1:0] o_prod,
    output logic [SW-1:0]    o_side
);
    logic             w_valid [0:BW];
    logic [AW-1:0]    w_a     [0:BW];
    logic [BW-1:0]    w_b     [0:BW];
    logic [AW+BW-1:0] w_acc   [0:BW];
    logic [SW-1:0]    w_side  [0:BW];

    assign w_valid[0] = i_valid;
    assign w_a[0]     = i_a;
    assign w_b[0]     = i_b;
    assign w_acc[0]   = '0;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < BW; g++) begin : g_cell
        tps_mul_cell #(.AW(AW), .BW(BW), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_a     (w_a[g]),
            .i_b     (w_b[g]),
            .i_acc   (w_acc[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_a     (w_a[g+1]),
            .o_b     (w_b[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[BW];
    assign o_prod  = w_acc[BW];
    assign o_side  = w_side[BW];

endmodule

>>> src/tps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tps_sqrt_cell: one step of a restoring integer square root chain
// Bring down two radicand bits, try the next root bit, keep the remainder.
// ----------------------------------------------------------------------------
module tps_sqrt_cell #(
    parameter int NW = 8,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [NW-1:0]       i_rad,
    input  logic [NW/2+1:0]     i_rem,
    input  logic [NW/2-1:0]     i_root,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [NW-1:0]       o_rad,
    output logic [NW/2+1:0]     o_rem,
    output logic [NW/2-1:0]     o_root,
    output logic [SW-1:0]       o_side
);
    localparam int RW   = NW / 2;
    localparam int REMW = RW + 2;

    logic              r_valid;
    logic [NW-1:0]     r_rad;
    logic [REMW-1:0]   r_rem;
    logic [RW-1:0]     r_root;
    logic [SW-1:0]     r_side;
    logic [REMW+1:0]   cand;
    logic [REMW+1:0]   trial;
    logic [REMW+1:0]   diff;
    logic              ge;
    logic [REMW-1:0]   n_rem;
    logic [RW-1:0]     n_root;

    always_comb begin
        cand   = {i_rem, i_rad[NW-1:NW-2]};
        trial  = (REMW+2)'({i_root, 2'b01});
        diff   = cand - trial;
        ge     = (cand >= trial);
        n_rem  = ge ? diff[REMW-1:0] : cand[REMW-1:0];
        n_root = {i_root[RW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rad  <= {i_rad[NW-3:0], 2'b00};
        r_rem  <= n_rem;
        r_root <= n_root;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

>>> src/tps_sqrt_chain.sv
// ----------------------------------------------------------------------------
// tps_sqrt_chain: pipelined floor square root built from a row of cells
// One cell per root bit; an odd radicand width is padded by one zero bit.
// ----------------------------------------------------------------------------
module tps_sqrt_chain #(
    parameter int NW = 8,
    parameter int SW = 1,
    localparam int RW = (NW + 1) / 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_rad,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);
    localparam int NE = 2 * RW;

    logic            w_valid [0:RW];
    logic [NE-1:0]   w_rad   [0:RW];
    logic [RW+1:0]   w_rem   [0:RW];
    logic [RW-1:0]   w_root  [0:RW];
    logic [SW-1:0]   w_side  [0:RW];

    assign w_valid[0] = i_valid;
    assign w_rad[0]   = NE'(i_rad);
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < RW; g++) begin : g_cell
        tps_sqrt_cell #(.NW(NE), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_rad   (w_rad[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[RW];
    assign o_root  = w_root[RW];
    assign o_side  = w_side[RW];

endmodule

>>> src/three_point_steiner_length.sv
// ----------------------------------------------------------------------------
// three_point_steiner_length: shortest network joining three planar points
// Throughput: every cell chain holds one word per stage, so one point triple
//   is taken on every cycle and busy stays low.
// Reset: synchronous, active low; it empties every stage and drops any word
//   in flight. The receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
module three_point_steiner_length #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  tps_pkg::t_points i_points,
    output logic             busy,
    output logic             o_valid,
    output tps_pkg::t_result o_result
);
    import tps_pkg::*;

    // Datapath widths; the arithmetic is scale free, so the fraction
    // position never enters here.
    localparam int C    = COORD_BITS;
    localparam int D2W  = 2 * C + 1;          // squared distance
    localparam int EW   = 2 * C + 2;          // x2 + y2 and |x2 + y2 - z2|
    localparam int PW   = 2 * EW;             // products and K
    localparam int K3W  = PW + 2;             // 3 * K
    localparam int RTW  = (K3W + 1) / 2;      // roots taken from K3W bits
    localparam int SSW  = 2 * C + 4;          // x2 + y2 + z2 + T
    localparam int RDW  = SSW - 1;            // half of that sum
    localparam int LW   = (RDW + 1) / 2;      // length before saturation
    localparam int LXW  = (LW > OUT_W) ? LW : OUT_W;
    localparam int S4W  = 3 * D2W + EW + 1;   // side word of the e*e chain
    localparam logic [C-1:0] SIGN_BIT = {1'b1, {(C-1){1'b0}}};

    // Map a signed coordinate onto an order-preserving unsigned code.
    function automatic logic [C-1:0] ord(input logic signed [IN_W-1:0] v);
        logic [C-1:0] w;
        w = C'(v);
        return w ^ SIGN_BIT;
    endfunction

    function automatic logic [C-1:0] adiff(input logic [C-1:0] a,
                                          input logic [C-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // ---------------------------------------------------------------
    // Input stage: coordinate differences for the three point pairs
    // (a-b, a-c, b-c).
    // ---------------------------------------------------------------
    logic [C-1:0] ax, ay, bx, by, cx, cy;
    logic [C-1:0] r_dx [3];
    logic [C-1:0] r_dy [3];
    logic         r_v0;

    always_comb begin
        ax = ord(i_points.point_a_x);
        ay = ord(i_points.point_a_y);
        bx = ord(i_points.point_b_x);
        by = ord(i_points.point_b_y);
        cx = ord(i_points.point_c_x);
        cy = ord(i_points.point_c_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
        r_dx[0] <= adiff(ax, bx);
        r_dy[0] <= adiff(ay, by);
        r_dx[1] <= adiff(ax, cx);
        r_dy[1] <= adiff(ay, cy);
        r_dx[2] <= adiff(bx, cx);
        r_dy[2] <= adiff(by, cy);
    end

    // ---------------------------------------------------------------
    // Squares of all six differences, one multiplier chain each.
    // ---------------------------------------------------------------
    logic [2*C-1:0] w_sqx [3];
    logic [2*C-1:0] w_sqy [3];
    logic [2:0]     w_sqx_v;
    logic [2:0]     w_sqy_v;

    for (genvar k = 0; k < 3; k++) begin : g_sq
        tps_mul_chain #(.AW(C), .BW(C), .SW(1)) u_sqx (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v0),
            .i_a     (r_dx[k]),
            .i_b     (r_dx[k]),
            .i_side  (1'b0),
            .o_valid (w_sqx_v[k]),
            .o_prod  (w_sqx[k]),
            .o_side  ()
        );
        tps_mul_chain #(.AW(C), .BW(C), .SW(1)) u_sqy (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v0),
            .i_a     (r_dy[k]),
            .i_b     (r_dy[k]),
            .i_side  (1'b0),
            .o_valid (w_sqy_v[k]),
            .o_prod  (w_sqy[k]),
            .o_side  ()
        );
    end

    // Squared distances.
    logic [D2W-1:0] r_d [3];
    logic           r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= &{w_sqx_v, w_sqy_v};
        end
        for (int k = 0; k < 3; k++) begin
            r_d[k] <= D2W'(w_sqx[k]) + D2W'(w_sqy[k]);
        end
    end

    // ---------------------------------------------------------------
    // Sort: three compares in parallel pick the smallest and largest
    // entry; the middle is the one left over. Ties give equal values, so
    // whichever entry wins a tie does not matter.
    // ---------------------------------------------------------------
    logic           gt01, gt02, gt12;
    logic [1:0]     imin, imax, imid;
    logic [D2W-1:0] r_x2, r_y2, r_z2;
    logic           r_v3;

    always_comb begin
        gt01 = (r_d[0] > r_d[1]);
        gt02 = (r_d[0] > r_d[2]);
        gt12 = (r_d[1] > r_d[2]);
        if (!gt01 && !gt02) begin
            imin = 2'd0;
        end else if (!gt12) begin
            imin = 2'd1;
        end else begin
            imin = 2'd2;
        end
        if (!gt02 && !gt12) begin
            imax = 2'd2;
        end else if (!gt01) begin
            imax = 2'd1;
        end else begin
            imax = 2'd0;
        end
        imid = 2'd3 - imin - imax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_x2 <= r_d[imin];
        r_y2 <= r_d[imid];
        r_z2 <= r_d[imax];
    end

    // ---------------------------------------------------------------
    // t = x2 + y2 and e = |t - z2|; z2 > t flags a possibly obtuse
    // triangle, and then e is exactly z2 - x2 - y2.
    // ---------------------------------------------------------------
    logic [EW-1:0]  t_sum;
    logic [EW-1:0]  r_t, r_e;
    logic [D2W-1:0] r_x2b, r_y2b, r_z2b;
    logic           r_gt;
    logic           r_v4;

    always_comb begin
        t_sum = EW'(r_x2) + EW'(r_y2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_t   <= t_sum;
        r_gt  <= (EW'(r_z2) > t_sum);
        r_e   <= (EW'(r_z2) > t_sum) ? (EW'(r_z2) - t_sum) : (t_sum - EW'(r_z2));
        r_x2b <= r_x2;
        r_y2b <= r_y2;
        r_z2b <= r_z2;
    end

    // e*e and x2*y2 side by side; the e*e chain carries the rest along.
    logic [PW-1:0]  w_ee, w_xy;
    logic [S4W-1:0] w_side4;
    logic           w_ee_v;
    logic           w_xy_v;

    tps_mul_chain #(.AW(EW), .BW(EW), .SW(S4W)) u_ee (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_a     (r_e),
        .i_b     (r_e),
        .i_side  ({r_x2b, r_y2b, r_z2b, r_t, r_gt}),
        .o_valid (w_ee_v),
        .o_prod  (w_ee),
        .o_side  (w_side4)
    );

    tps_mul_chain #(.AW(EW), .BW(EW), .SW(1)) u_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_a     (EW'(r_x2b)),
        .i_b     (EW'(r_y2b)),
        .i_side  (1'b0),
        .o_valid (w_xy_v),
        .o_prod  (w_xy),
        .o_side  ()
    );

    // ---------------------------------------------------------------
    // Obtuse test and area radicand K = 4*x2*y2 - e^2, clamped at zero.
    // ---------------------------------------------------------------
    logic [D2W-1:0] s4_x2, s4_y2, s4_z2;
    logic [EW-1:0]  s4_t;
    logic           s4_gt;
    logic [PW-1:0]  xy4;
    logic [PW-1:0]  r_k;
    logic [SSW-1:0] r_s0;
    logic [D2W-1:0] r_x2c, r_y2c;
    logic           r_obt5;
    logic           r_v5;

    always_comb begin
        {s4_x2, s4_y2, s4_z2, s4_t, s4_gt} = w_side4;
        xy4 = {w_xy[PW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= w_ee_v && w_xy_v;
        end
        r_obt5 <= s4_gt && (w_ee > w_xy);
        r_k    <= (xy4 > w_ee) ? (xy4 - w_ee) : '0;
        r_s0   <= SSW'(s4_t) + SSW'(s4_z2);
        r_x2c  <= s4_x2;
        r_y2c  <= s4_y2;
    end

    // 3*K as K + 2K.
    logic [K3W-1:0] r_k3;
    logic [SSW-1:0] r_s0b;
    logic [D2W-1:0] r_x2d, r_y2d;
    logic           r_obt6;
    logic           r_v6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_k3   <= K3W'(r_k) + K3W'({r_k, 1'b0});
        r_s0b  <= r_s0;
        r_x2d  <= r_x2c;
        r_y2d  <= r_y2c;
        r_obt6 <= r_obt5;
    end

    // ---------------------------------------------------------------
    // Three roots of equal depth: sqrt(x2), sqrt(y2), T = sqrt(3K).
    // ---------------------------------------------------------------
    logic [RTW-1:0]   w_rx, w_ry, w_tr;
    logic [SSW:0]     w_side6;
    logic             w_rx_v, w_ry_v, w_tr_v;

    tps_sqrt_chain #(.NW(K3W), .SW(1)) u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_rad   (K3W'(r_x2d)),
        .i_side  (1'b0),
        .o_valid (w_rx_v),
        .o_root  (w_rx),
        .o_side  ()
    );

    tps_sqrt_chain #(.NW(K3W), .SW(1)) u_ry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_rad   (K3W'(r_y2d)),
        .i_side  (1'b0),
        .o_valid (w_ry_v),
        .o_root  (w_ry),
        .o_side  ()
    );

    tps_sqrt_chain #(.NW(K3W), .SW(SSW+1)) u_tr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_rad   (r_k3),
        .i_side  ({r_s0b, r_obt6}),
        .o_valid (w_tr_v),
        .o_root  (w_tr),
        .o_side  (w_side6)
    );

    // Sum of the shorter sides, and half of x2 + y2 + z2 + T.
    logic [SSW-1:0] s6_s0;
    logic           s6_obt;
    logic [SSW-1:0] s_all;
    logic [LW-1:0]  r_sxy;
    logic [RDW-1:0] r_half;
    logic           r_obt7;
    logic           r_v7;

    always_comb begin
        {s6_s0, s6_obt} = w_side6;
        s_all = s6_s0 + SSW'(w_tr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= w_rx_v && w_ry_v && w_tr_v;
        end
        r_sxy  <= LW'(w_rx) + LW'(w_ry);
        r_half <= s_all[SSW-1:1];
        r_obt7 <= s6_obt;
    end

    // Final root of the non-obtuse branch.
    logic [LW-1:0] w_len;
    logic [LW:0]   w_side7;
    logic          w_len_v;

    tps_sqrt_chain #(.NW(RDW), .SW(LW+1)) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_rad   (r_half),
        .i_side  ({r_sxy, r_obt7}),
        .o_valid (w_len_v),
        .o_root  (w_len),
        .o_side  (w_side7)
    );

    // ---------------------------------------------------------------
    // Output: pick the branch, saturate to the field width, strobe.
    // Hold the payload between results.
    // ---------------------------------------------------------------
    logic [LW-1:0]  s7_sxy;
    logic           s7_obt;
    logic [LXW-1:0] len_ext;
    logic [OUT_W-1:0] len_sat;
    t_result        r_res;
    logic           r_valid;

    always_comb begin
        {s7_sxy, s7_obt} = w_side7;
        len_ext = LXW'(s7_obt ? s7_sxy : w_len);
        len_sat = ((len_ext >> OUT_W) != '0) ? '1 : len_ext[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_len_v;
        end
        if (w_len_v) begin
            r_res.network_length <= len_sat;
            r_res.obtuse_case    <= s7_obt;
        end
    end

    assign busy     = 1'b0;
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

>>> src/tps_check.sv
// ----------------------------------------------------------------------------
// tps_check: port-level checks for the three-point Steiner length block
// Fixed latency, no stall, and a quiet result word between strobes.
// ----------------------------------------------------------------------------
module tps_check #(
    parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input tps_pkg::t_points i_points,
    input logic             busy,
    input logic             o_valid,
    input tps_pkg::t_result o_result
);
    import tps_pkg::*;

    localparam int LAT = 6 * COORD_BITS + 15;

    // The block never refuses a word.
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Every result traces back to a start exactly one latency earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result without matching start");

    // Between strobes the result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> $stable(o_result))
        else $error("result word moved without strobe");

endmodule

bind three_point_steiner_length tps_check #(.COORD_BITS(COORD_BITS)) u_tps_check (.*);
